### rtl/nmea_rmc_position_parser_defines.svh
// ----------------------------------------------------------------------------
// NMEA RMC position parser assertion macros
// Immediate-implication and next-cycle-implication checks, clocked on clk
// and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_POSITION_PARSER_DEFINES_SVH
`define NMEA_RMC_POSITION_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NRP_ASSERT_HOLDS(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NRP_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

### rtl/nrp_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC position parser package
// Number format limits, character codes, field indexes and state types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrp_pkg;

	// Number format: integer digits (DDDMM) and kept fraction digits
	localparam int INT_DIGITS  = 5;
	localparam int FRAC_DIGITS = 4;

	localparam longint unsigned SCALE        = 64'd10 ** FRAC_DIGITS;
	localparam longint unsigned DEG_MAX      = (64'd10 ** (INT_DIGITS - 2)) - 64'd1;
	localparam longint unsigned UDEG_PER_DEG = 64'd1000000;
	localparam longint unsigned MAG_MAX      = (64'd1 << 30) - 64'd1;

	localparam int DEG_W  = $clog2(DEG_MAX * 64'd10 + 64'd10);
	localparam int FRAC_W = (FRAC_DIGITS > 0) ? $clog2(SCALE) : 1;
	localparam int FD_W   = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
	localparam int MIN_W  = $clog2(SCALE * 64'd100);

	// minutes * 10^6 / (60 * SCALE) reduced to minutes * MUL / DIV
	localparam int G2 = (FRAC_DIGITS + 2 < 6) ? FRAC_DIGITS + 2 : 6;
	localparam int G5 = (FRAC_DIGITS + 1 < 6) ? FRAC_DIGITS + 1 : 6;
	localparam longint unsigned GCD_MD = (64'd2 ** G2) * (64'd5 ** G5);
	localparam longint unsigned MUL    = UDEG_PER_DEG / GCD_MD;
	localparam longint unsigned DIV    = (64'd60 * SCALE) / GCD_MD;

	// Reciprocal for an exact floor(x / DIV) over the whole range of x
	localparam longint unsigned X_MAX   = (SCALE * 64'd100 - 64'd1) * MUL;
	localparam int              X_W     = $clog2(X_MAX + 64'd1);
	localparam int              DIV_L   = $clog2(DIV);
	localparam int              SHIFT   = X_W + DIV_L;
	localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + DIV - 64'd1) / DIV;
	localparam int              RECIP_W = $clog2(RECIP + 64'd1);
	localparam int              PROD_W  = X_W + RECIP_W;
	localparam int              QUOT_W  = $clog2(X_MAX / DIV + 64'd1);

	localparam int DEGSC_W = $clog2(DEG_MAX * UDEG_PER_DEG + 64'd1);
	localparam int MAG_W   = ((DEGSC_W > QUOT_W) ? DEGSC_W : QUOT_W) + 1;
	localparam int COORD_W = 31;

	// Character codes
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;

	localparam logic [2:0] PREFIX_LEN = 3'd6;

	// Comma field indexes
	localparam logic [2:0] FLD_STATUS = 3'd2;
	localparam logic [2:0] FLD_LAT    = 3'd3;
	localparam logic [2:0] FLD_NS     = 3'd4;
	localparam logic [2:0] FLD_LON    = 3'd5;
	localparam logic [2:0] FLD_EW     = 3'd6;
	localparam logic [2:0] FLD_LAST   = 3'd7;

	// Number being parsed: degrees, last two integer digits, scaled fraction
	typedef struct packed {
		logic [DEG_W-1:0]  deg;
		logic [3:0]        tens;
		logic [3:0]        units;
		logic [FRAC_W-1:0] frac;
		logic [FD_W-1:0]   fd;
		logic              ended;
		logic              in_frac;
		logic              digit;
		logic              bad;
	} num_t;

	// Per-line parse state
	typedef struct packed {
		logic [2:0] prefix_pos;
		logic       prefix_ok;
		logic [2:0] field_idx;
		logic       field_has_chars;
		logic [1:0] status_len;
		logic       status_is_a;
		num_t       lat;
		num_t       lon;
		logic       lat_south;
		logic       lon_west;
	} line_t;

	// Line-end snapshot
	typedef struct packed {
		logic               good;
		logic               lat_neg;
		logic               lon_neg;
		logic [DEGSC_W-1:0] lat_degsc;
		logic [MIN_W-1:0]   lat_min;
		logic [DEGSC_W-1:0] lon_degsc;
		logic [MIN_W-1:0]   lon_min;
	} snap_t;

	// Converted parts ready for the final sum
	typedef struct packed {
		logic               good;
		logic               lat_neg;
		logic               lon_neg;
		logic [DEGSC_W-1:0] lat_degsc;
		logic [QUOT_W-1:0]  lat_quot;
		logic [DEGSC_W-1:0] lon_degsc;
		logic [QUOT_W-1:0]  lon_quot;
	} part_t;

endpackage

### rtl/nmea_rmc_position_parser.sv
// ----------------------------------------------------------------------------
// NMEA RMC position parser: one received byte per item, one result per newline
// Throughput: one byte per cycle unless a newline stalls; the per-byte parse update is a
// single stage. Reset clears the valid flags and state. A newline's result passes the
// byte register, line snapshot, divide-by-constant multiplier stage and sum-and-store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nmea_rmc_position_parser_defines.svh"

module nmea_rmc_position_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  logic [7:0]              rx_byte,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic                    line_updated,
	output logic                    fix_valid,
	output logic signed [30:0]      latitude_udeg,
	output logic signed [30:0]      longitude_udeg
);

	// Empty line state: everything zero, prefix still matching
	function automatic nrp_pkg::line_t line_clear();
		nrp_pkg::line_t r;
		r           = '0;
		r.prefix_ok = 1'b1;
		return r;
	endfunction

	// Place weight of a fraction digit: 10^(FRAC_DIGITS-1-k)
	function automatic logic [nrp_pkg::FRAC_W-1:0] frac_weight(
		input logic [nrp_pkg::FD_W-1:0] k
	);
		logic [nrp_pkg::FRAC_W-1:0] w;
		w = nrp_pkg::FRAC_W'(1);
		for (int i = 0; i < nrp_pkg::FRAC_DIGITS; i++) begin
			if (i > int'(k)) begin
				w = nrp_pkg::FRAC_W'(w * nrp_pkg::FRAC_W'(10));
			end
		end
		return w;
	endfunction

	// Advance a number by one character of its field
	function automatic nrp_pkg::num_t num_step(
		input nrp_pkg::num_t n,
		input logic [7:0]    b,
		input logic          first
	);
		nrp_pkg::num_t          r;
		logic                   dig;
		logic [3:0]             d;
		logic [nrp_pkg::DEG_W-1:0] deg_new;
		r       = n;
		dig     = (b >= nrp_pkg::CH_0) && (b <= nrp_pkg::CH_9);
		d       = b[3:0];
		deg_new = nrp_pkg::DEG_W'(n.deg * nrp_pkg::DEG_W'(10)) + nrp_pkg::DEG_W'(n.tens);
		if (!(n.ended || n.bad)) begin
			if (first && !dig && (b != nrp_pkg::CH_DOT)) begin
				r.bad = 1'b1;
			end else if (dig) begin
				r.digit = 1'b1;
				if (n.in_frac) begin
					if (n.fd < nrp_pkg::FD_W'(nrp_pkg::FRAC_DIGITS)) begin
						r.frac = n.frac + nrp_pkg::FRAC_W'(nrp_pkg::FRAC_W'(d)
							* frac_weight(n.fd));
						r.fd   = n.fd + nrp_pkg::FD_W'(1);
					end
				end else begin
					// shift one digit in: DDD gains the old tens digit
					r.deg   = deg_new;
					r.tens  = n.units;
					r.units = d;
					if (64'(deg_new) > nrp_pkg::DEG_MAX) begin
						r.bad = 1'b1;
					end
				end
			end else if ((b == nrp_pkg::CH_DOT) && !n.in_frac) begin
				r.in_frac = 1'b1;
			end else begin
				r.ended = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [nrp_pkg::DEGSC_W-1:0] num_degsc(input nrp_pkg::num_t n);
		return nrp_pkg::DEGSC_W'(n.deg) * nrp_pkg::DEGSC_W'(nrp_pkg::UDEG_PER_DEG);
	endfunction

	// Minutes scaled by 10^FRAC_DIGITS
	function automatic logic [nrp_pkg::MIN_W-1:0] num_minutes(input nrp_pkg::num_t n);
		logic [6:0] mm;
		mm = 7'(7'(n.tens) * 7'd10) + 7'(n.units);
		return nrp_pkg::MIN_W'(nrp_pkg::MIN_W'(mm) * nrp_pkg::MIN_W'(nrp_pkg::SCALE))
			+ nrp_pkg::MIN_W'(n.frac);
	endfunction

	// Floor of the scaled minutes converted to microdegrees
	function automatic logic [nrp_pkg::QUOT_W-1:0] min_to_udeg(
		input logic [nrp_pkg::MIN_W-1:0] m
	);
		logic [nrp_pkg::X_W-1:0]    x;
		logic [nrp_pkg::PROD_W-1:0] p;
		x = nrp_pkg::X_W'(m) * nrp_pkg::X_W'(nrp_pkg::MUL);
		p = nrp_pkg::PROD_W'(x) * nrp_pkg::PROD_W'(nrp_pkg::RECIP);
		return p[nrp_pkg::SHIFT +: nrp_pkg::QUOT_W];
	endfunction

	// Saturate the magnitude and apply the hemisphere sign
	function automatic logic [nrp_pkg::COORD_W-1:0] to_coord(
		input logic [nrp_pkg::DEGSC_W-1:0] degsc,
		input logic [nrp_pkg::QUOT_W-1:0]  quot,
		input logic                        neg
	);
		logic [nrp_pkg::MAG_W-1:0]     mag;
		logic [nrp_pkg::COORD_W-2:0]   m30;
		logic [nrp_pkg::COORD_W-1:0]   pos;
		mag = nrp_pkg::MAG_W'(degsc) + nrp_pkg::MAG_W'(quot);
		if (64'(mag) > nrp_pkg::MAG_MAX) begin
			m30 = (nrp_pkg::COORD_W-1)'(nrp_pkg::MAG_MAX);
		end else begin
			m30 = (nrp_pkg::COORD_W-1)'(mag);
		end
		pos = {1'b0, m30};
		return neg ? (~pos + nrp_pkg::COORD_W'(1)) : pos;
	endfunction

	logic [7:0]             byte_s1;
	logic                   vld_s1;
	logic                   nl_s1;
	logic                   cr_s1;
	logic                   consume_s1;
	nrp_pkg::line_t         line_q;
	nrp_pkg::line_t         line_d;
	logic                   prefix_hit;
	logic                   line_good;
	nrp_pkg::snap_t         snap_s2;
	logic                   vld_s2;
	nrp_pkg::part_t         part_s3;
	logic                   vld_s3;
	logic                   res_vld_q;
	logic                   line_upd_q;
	logic                   fix_seen_q;
	logic [30:0]            stored_lat_q;
	logic [30:0]            stored_lon_q;
	logic                   out_free;
	logic                   free3;
	logic                   free2;

	// Stage flow: each stage moves when the one after it is empty or moving
	assign out_free   = !res_vld_q || !result_stall;
	assign free3      = !vld_s3 || out_free;
	assign free2      = !vld_s2 || free3;
	assign nl_s1      = (byte_s1 == nrp_pkg::CH_LF);
	assign cr_s1      = (byte_s1 == nrp_pkg::CH_CR);
	assign consume_s1 = vld_s1 && (!nl_s1 || free2);
	assign byte_stall = vld_s1 && !consume_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			vld_s1 <= 1'b1;
		end else if (consume_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Line-end verdict from the state built so far
	always_comb begin
		line_good = line_q.prefix_ok && (line_q.prefix_pos == nrp_pkg::PREFIX_LEN)
			&& ((line_q.field_idx == nrp_pkg::FLD_LAST)
				|| ((line_q.field_idx == nrp_pkg::FLD_EW) && line_q.field_has_chars))
			&& (line_q.status_len == 2'd1) && line_q.status_is_a
			&& !line_q.lat.bad && line_q.lat.digit
			&& !line_q.lon.bad && line_q.lon.digit;
	end

	// Per-byte parse update
	always_comb begin
		line_d     = line_q;
		prefix_hit = 1'b0;
		if (nl_s1) begin
			line_d = line_clear();
		end else if (!cr_s1) begin
			// check the sentence prefix
			if (line_q.prefix_pos < nrp_pkg::PREFIX_LEN) begin
				case (line_q.prefix_pos)
					3'd0: prefix_hit = (byte_s1 == nrp_pkg::CH_DOLLAR);
					3'd1: prefix_hit = (byte_s1 == nrp_pkg::CH_G);
					3'd2: prefix_hit = byte_s1 inside {nrp_pkg::CH_P, nrp_pkg::CH_N};
					3'd3: prefix_hit = (byte_s1 == nrp_pkg::CH_R);
					3'd4: prefix_hit = (byte_s1 == nrp_pkg::CH_M);
					default: prefix_hit = (byte_s1 == nrp_pkg::CH_C);
				endcase
				if (!prefix_hit) begin
					line_d.prefix_ok = 1'b0;
				end
				line_d.prefix_pos = line_q.prefix_pos + 3'd1;
			end
			if (byte_s1 == nrp_pkg::CH_COMMA) begin
				// advance to the next field, saturating
				if (line_q.field_idx != nrp_pkg::FLD_LAST) begin
					line_d.field_idx = line_q.field_idx + 3'd1;
				end
				line_d.field_has_chars = 1'b0;
			end else begin
				case (line_q.field_idx)
					nrp_pkg::FLD_STATUS: begin
						if (!line_q.field_has_chars) begin
							line_d.status_is_a = (byte_s1 == nrp_pkg::CH_A);
						end
						if (line_q.status_len != 2'd2) begin
							line_d.status_len = line_q.status_len + 2'd1;
						end
					end
					nrp_pkg::FLD_LAT: begin
						line_d.lat = num_step(line_q.lat, byte_s1, !line_q.field_has_chars);
					end
					nrp_pkg::FLD_NS: begin
						if (!line_q.field_has_chars) begin
							line_d.lat_south = (byte_s1 == nrp_pkg::CH_S);
						end
					end
					nrp_pkg::FLD_LON: begin
						line_d.lon = num_step(line_q.lon, byte_s1, !line_q.field_has_chars);
					end
					nrp_pkg::FLD_EW: begin
						if (!line_q.field_has_chars) begin
							line_d.lon_west = (byte_s1 == nrp_pkg::CH_W);
						end
					end
					default: begin
					end
				endcase
				line_d.field_has_chars = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= line_clear();
		end else if (consume_s1) begin
			line_q <= line_d;
		end
	end

	// Snapshot the line at its newline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (consume_s1 && nl_s1) begin
			vld_s2 <= 1'b1;
		end else if (free3) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume_s1 && nl_s1) begin
			snap_s2.good      <= line_good;
			snap_s2.lat_neg   <= line_q.lat_south;
			snap_s2.lon_neg   <= line_q.lon_west;
			snap_s2.lat_degsc <= num_degsc(line_q.lat);
			snap_s2.lat_min   <= num_minutes(line_q.lat);
			snap_s2.lon_degsc <= num_degsc(line_q.lon);
			snap_s2.lon_min   <= num_minutes(line_q.lon);
		end
	end

	// Convert minutes to microdegrees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (vld_s2 && free3) begin
			vld_s3 <= 1'b1;
		end else if (out_free) begin
			vld_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && free3) begin
			part_s3.good      <= snap_s2.good;
			part_s3.lat_neg   <= snap_s2.lat_neg;
			part_s3.lon_neg   <= snap_s2.lon_neg;
			part_s3.lat_degsc <= snap_s2.lat_degsc;
			part_s3.lat_quot  <= min_to_udeg(snap_s2.lat_min);
			part_s3.lon_degsc <= snap_s2.lon_degsc;
			part_s3.lon_quot  <= min_to_udeg(snap_s2.lon_min);
		end
	end

	// Result register; a good line updates the stored position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q    <= 1'b0;
			line_upd_q   <= 1'b0;
			fix_seen_q   <= 1'b0;
			stored_lat_q <= '0;
			stored_lon_q <= '0;
		end else if (out_free) begin
			res_vld_q <= vld_s3;
			if (vld_s3) begin
				line_upd_q <= part_s3.good;
				if (part_s3.good) begin
					fix_seen_q   <= 1'b1;
					stored_lat_q <= to_coord(part_s3.lat_degsc, part_s3.lat_quot,
						part_s3.lat_neg);
					stored_lon_q <= to_coord(part_s3.lon_degsc, part_s3.lon_quot,
						part_s3.lon_neg);
				end
			end
		end
	end

	assign result_valid   = res_vld_q;
	assign line_updated   = line_upd_q;
	assign fix_valid      = fix_seen_q;
	assign latitude_udeg  = stored_lat_q;
	assign longitude_udeg = stored_lon_q;

	// Checks
	`NRP_ASSERT_HOLDS(a_upd_has_fix, result_valid && line_updated, fix_valid, "update without fix")
	`NRP_ASSERT_HOLDS(a_stall_cause, byte_stall, vld_s1 && nl_s1 && vld_s2, "stall without newline")
	`NRP_ASSERT_NEXT(a_newline_snap, consume_s1 && nl_s1, vld_s2, "newline lost")
	`NRP_ASSERT_HOLDS(a_fix_sticky, 1'b1, !$fell(fix_seen_q), "fix flag dropped")

endmodule

### verif/tb_nmea_rmc_position_parser.sv
// ----------------------------------------------------------------------------
// NMEA RMC position parser testbench
// Streams sentence bytes into the parser and checks every per-line result
// against a byte-level model of the RMC parse and the position conversion.
// A directed set of corner-case lines runs first, then random sentences,
// broken lines and raw noise. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nmea_rmc_position_parser;

	localparam int BYTE_TARGET  = 1700;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 10;

	// Number being parsed out of a latitude or longitude field
	typedef struct {
		longint unsigned whole;
		longint unsigned frac;
		int              frac_cnt;
		bit              ended;
		bit              in_frac;
		bit              seen_digit;
		bit              bad;
	} coord_num_t;

	// One line result as the parser should report it
	typedef struct {
		bit                 updated;
		bit                 valid;
		logic signed [30:0] lat;
		logic signed [30:0] lon;
	} fix_report_t;

	class position_scoreboard;
		int                 prefix_pos;
		bit                 prefix_ok;
		int                 field_idx;
		bit                 has_chars;
		int                 status_len;
		bit                 status_a;
		coord_num_t         lat_num;
		coord_num_t         lon_num;
		bit                 lat_south;
		bit                 lon_west;
		logic signed [30:0] stored_lat;
		logic signed [30:0] stored_lon;
		bit                 fix_seen;
		fix_report_t        pending[$];
		int                 mismatches;
		int                 lines_noted;
		int                 lines_checked;
		int                 good_fixes;

		function new();
			clear_line();
			stored_lat    = '0;
			stored_lon    = '0;
			fix_seen      = 1'b0;
			mismatches    = 0;
			lines_noted   = 0;
			lines_checked = 0;
			good_fixes    = 0;
		endfunction

		function void clear_line();
			prefix_pos = 0;
			prefix_ok  = 1'b1;
			field_idx  = 0;
			has_chars  = 1'b0;
			status_len = 0;
			status_a   = 1'b0;
			lat_num    = '{default: 0};
			lon_num    = '{default: 0};
			lat_south  = 1'b0;
			lon_west   = 1'b0;
		endfunction

		function longint unsigned pow10(int n);
			longint unsigned r;
			r = 1;
			for (int i = 0; i < n; i++)
				r = r * 10;
			return r;
		endfunction

		// Advance the number parse by one field character
		function coord_num_t advance_number(coord_num_t n, logic [7:0] b, bit first);
			bit is_digit;
			is_digit = (b >= nrp_pkg::CH_0) && (b <= nrp_pkg::CH_9);
			if (n.ended || n.bad)
				return n;
			if (first && !is_digit && b != nrp_pkg::CH_DOT) begin
				n.bad = 1'b1;
				return n;
			end
			if (is_digit) begin
				n.seen_digit = 1'b1;
				if (n.in_frac) begin
					// drop fraction digits past the kept count
					if (n.frac_cnt < nrp_pkg::FRAC_DIGITS) begin
						n.frac = n.frac * 10 + (b - nrp_pkg::CH_0);
						n.frac_cnt++;
					end
				end else begin
					n.whole = n.whole * 10 + (b - nrp_pkg::CH_0);
					if (n.whole > pow10(nrp_pkg::INT_DIGITS) - 1)
						n.bad = 1'b1;
				end
			end else if (b == nrp_pkg::CH_DOT && !n.in_frac) begin
				n.in_frac = 1'b1;
			end else begin
				n.ended = 1'b1;
			end
			return n;
		endfunction

		function bit number_ok(coord_num_t n);
			return !n.bad && n.seen_digit;
		endfunction

		// Convert DDDMM.MMMM to microdegrees, truncated, then apply the sign
		function logic signed [30:0] to_microdeg(coord_num_t n, bit negate);
			longint unsigned scale;
			longint unsigned minutes;
			longint unsigned mag;
			longint          signed_mag;
			scale   = pow10(nrp_pkg::FRAC_DIGITS);
			minutes = (n.whole % 100) * scale
				+ n.frac * pow10(nrp_pkg::FRAC_DIGITS - n.frac_cnt);
			mag     = (n.whole / 100) * nrp_pkg::UDEG_PER_DEG
				+ (minutes * nrp_pkg::UDEG_PER_DEG) / (60 * scale);
			if (mag > nrp_pkg::MAG_MAX)
				mag = nrp_pkg::MAG_MAX;
			signed_mag = negate ? -longint'(mag) : longint'(mag);
			return signed_mag[30:0];
		endfunction

		// Note an accepted byte; a newline queues the line result
		function void note_byte(logic [7:0] b);
			bit          fields_ok;
			bit          good;
			bit          hit;
			fix_report_t rep;
			if (b == nrp_pkg::CH_CR)
				return;
			if (b == nrp_pkg::CH_LF) begin
				fields_ok = (field_idx >= nrp_pkg::FLD_LAST)
					|| (field_idx == nrp_pkg::FLD_EW && has_chars);
				good = prefix_ok && prefix_pos >= nrp_pkg::PREFIX_LEN && fields_ok &&
					status_len == 1 && status_a && number_ok(lat_num) && number_ok(lon_num);
				if (good) begin
					stored_lat = to_microdeg(lat_num, lat_south);
					stored_lon = to_microdeg(lon_num, lon_west);
					fix_seen   = 1'b1;
					good_fixes++;
				end
				rep.updated = good;
				rep.valid   = fix_seen;
				rep.lat     = stored_lat;
				rep.lon     = stored_lon;
				pending.insert(pending.size(), rep);
				lines_noted++;
				clear_line();
				return;
			end
			// Match the sentence prefix one character at a time
			if (prefix_pos < nrp_pkg::PREFIX_LEN) begin
				case (prefix_pos)
					0: hit = (b == nrp_pkg::CH_DOLLAR);
					1: hit = (b == nrp_pkg::CH_G);
					2: hit = (b == nrp_pkg::CH_P) || (b == nrp_pkg::CH_N);
					3: hit = (b == nrp_pkg::CH_R);
					4: hit = (b == nrp_pkg::CH_M);
					default: hit = (b == nrp_pkg::CH_C);
				endcase
				if (!hit)
					prefix_ok = 1'b0;
				prefix_pos++;
			end
			if (b == nrp_pkg::CH_COMMA) begin
				if (field_idx < nrp_pkg::FLD_LAST)
					field_idx++;
				has_chars = 1'b0;
				return;
			end
			case (field_idx)
				nrp_pkg::FLD_STATUS: begin
					if (!has_chars)
						status_a = (b == nrp_pkg::CH_A);
					if (status_len < 2)
						status_len++;
				end
				nrp_pkg::FLD_LAT: lat_num = advance_number(lat_num, b, !has_chars);
				nrp_pkg::FLD_NS: begin
					if (!has_chars)
						lat_south = (b == nrp_pkg::CH_S);
				end
				nrp_pkg::FLD_LON: lon_num = advance_number(lon_num, b, !has_chars);
				nrp_pkg::FLD_EW: begin
					if (!has_chars)
						lon_west = (b == nrp_pkg::CH_W);
				end
				default: ;
			endcase
			has_chars = 1'b1;
		endfunction

		// Compare one accepted result with the oldest queued line
		function void check_result(bit updated, bit valid, logic signed [30:0] lat,
				logic signed [30:0] lon);
			fix_report_t want;
			if (pending.size() == 0) begin
				$error("result with no line pending: line_updated %0d", updated);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			lines_checked++;
			if (updated !== want.updated) begin
				$error("line_updated: expected %0d, got %0d", want.updated, updated);
				mismatches++;
			end
			if (valid !== want.valid) begin
				$error("fix_valid: expected %0d, got %0d", want.valid, valid);
				mismatches++;
			end
			if (lat !== want.lat) begin
				$error("latitude_udeg: expected %0d, got %0d", want.lat, lat);
				mismatches++;
			end
			if (lon !== want.lon) begin
				$error("longitude_udeg: expected %0d, got %0d", want.lon, lon);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               byte_valid   = 1'b0;
	logic               byte_stall;
	logic [7:0]         rx_byte      = 8'h00;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               line_updated;
	logic               fix_valid;
	logic signed [30:0] latitude_udeg;
	logic signed [30:0] longitude_udeg;

	position_scoreboard board;
	logic [7:0]         line_buf[$];
	bit                 steady = 1'b0;
	int                 bytes_sent = 0;
	int                 hold_target = 0;
	int                 hold_count = 0;

	always #1 clk = ~clk;

	nmea_rmc_position_parser i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.rx_byte        (rx_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.line_updated   (line_updated),
		.fix_valid      (fix_valid),
		.latitude_udeg  (latitude_udeg),
		.longitude_udeg (longitude_udeg)
	);

	// Check each accepted result, then hold stall for a random number of
	// cycles of the next result being offered
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				board.check_result(line_updated, fix_valid, latitude_udeg, longitude_udeg);
				hold_target = steady ? 0 : $urandom_range(0, 4);
				hold_count  = 0;
				result_stall <= (hold_target != 0);
			end else if (result_valid && result_stall) begin
				hold_count++;
				if (hold_count >= hold_target)
					result_stall <= 1'b0;
			end
		end
	end

	// Offer one byte after a random gap and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		rx_byte    <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		board.note_byte(b);
		bytes_sent++;
	endtask

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.insert(line_buf.size(), s[i]);
	endfunction

	task automatic send_line();
		while (line_buf.size() != 0)
			send_byte(line_buf.pop_front());
	endtask

	task automatic send_text(string s);
		add_text(s);
		send_line();
	endtask

	function automatic string digit_run(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		return s;
	endfunction

	// Coordinate text: mostly well-formed, with the usual ways to break it
	function automatic string coord_text(int whole_digits);
		string s;
		case ($urandom_range(0, 13))
			0: s = "";
			1: s = {"-", digit_run(whole_digits)};
			2: s = {".", digit_run($urandom_range(0, 3))};
			3: s = digit_run(whole_digits + 1 + $urandom_range(0, 2));
			4: s = {"000", digit_run(whole_digits), ".", digit_run(2)};
			5: s = {digit_run(whole_digits), ".", digit_run(2), ".", digit_run(2)};
			6: s = {digit_run($urandom_range(1, whole_digits)), "x7"};
			7: s = "99999.99999999";
			default: s = {digit_run($urandom_range(1, whole_digits)), ".",
				digit_run($urandom_range(0, 8))};
		endcase
		return s;
	endfunction

	function automatic string hemi_text(string neg, string pos);
		string s;
		case ($urandom_range(0, 7))
			0: s = "";
			1: s = {neg, "X"};
			2: s = "Q";
			default: s = $urandom_range(0, 1) ? neg : pos;
		endcase
		return s;
	endfunction

	// Build one RMC sentence with random content into the line buffer
	function automatic void add_sentence();
		string head;
		string status;
		case ($urandom_range(0, 11))
			0: head = "$GPRMX";
			1: head = "$GLRMC";
			2: head = "GPRMC,";
			default: head = $urandom_range(0, 1) ? "$GPRMC" : "$GNRMC";
		endcase
		case ($urandom_range(0, 9))
			0: status = "V";
			1: status = "";
			2: status = "AA";
			default: status = "A";
		endcase
		add_text({head, ",", digit_run(6), ".00,", status});
		add_text({",", coord_text(4), ",", hemi_text("S", "N")});
		add_text({",", coord_text(5), ",", hemi_text("W", "E")});
		case ($urandom_range(0, 5))
			0: ;
			1: add_text(",");
			default: add_text({",", digit_run(3), ".", digit_run(1), ",084.4,",
				digit_run(6), ",003.1,W*6A"});
		endcase
		if ($urandom_range(0, 1))
			add_text("\015");
		add_text("\n");
	endfunction

	initial begin
		int cut;
		int noise_len;
		board = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed lines: no prefix, range extremes, syntax corner cases
		send_text("\n");
		send_text("hello, world\015\n");
		send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\015\n");
		send_text("$GNRMC,,A,99999.99999,S,99999.9999,W,\n");
		send_text("$GPRMC,,A,0000.0000,N,00000.0000,E,,\n");
		send_text("$GPRMC,,A,00,S,0,W,\n");
		send_text("$GPRMC,,A,.5,N,.25,E,\n");
		send_text("$GPRMC,,A,.,N,1.0,E,\n");
		send_text("$GPRMC,,A,100000,N,1.0,E,\n");
		send_text("$GPRMC,,A,0000012345.6,N,000099999,E,\n");
		send_text("$GPRMC,,V,4807.038,N,01131.000,E,\n");
		send_text("$GPRMC,,AA,4807.038,N,01131.000,E,\n");
		send_text("$GPRMC,,,4807.038,N,01131.000,E,\n");
		send_text("$GPRMC,,A,4807.038,S,01131.000,W\n");
		send_text("$GPRMC,,A,4807.038,N,01131.000,\n");
		send_text("$GPRMC,,A,12.34.56,S,1.2x9,W,\n");
		send_text("$GPRMC,,A,-12.3,N,1.0,E,\n");
		send_text("$GPRMC,,A, 12,N,1.0,E,\n");
		send_text("$GPRMC,,A,1e3,N,4807.12345678,E,\n");
		send_text("$GPRMC,,A,4807.038,,01131.000,,\n");
		send_text("$GPRMC,,A,4807.038,W,01131.000,S,\n");
		send_text("$GP\015RMC,,A,1,SOUTH,2,WEST,,,,,,,,,,,,,,,,,\n");
		send_text("$GLRMC,,A,1,N,1,E,\n");
		send_text("$GPRM\n");
		line_buf.insert(line_buf.size(), 8'h00);
		line_buf.insert(line_buf.size(), 8'hFF);
		line_buf.insert(line_buf.size(), nrp_pkg::CH_LF);
		send_line();
		steady = 1'b1;
		send_text("\n\n\n\n\n\n");

		// Random lines: mostly whole sentences, some cut short, some noise
		while (bytes_sent < BYTE_TARGET) begin
			steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: begin
					noise_len = $urandom_range(1, 20);
					repeat (noise_len)
						line_buf.insert(line_buf.size(), 8'($urandom_range(0, 255)));
					line_buf.insert(line_buf.size(), nrp_pkg::CH_LF);
				end
				1: begin
					add_sentence();
					cut = $urandom_range(1, line_buf.size() - 1);
					while (line_buf.size() > cut)
						void'(line_buf.pop_back());
					line_buf.insert(line_buf.size(), nrp_pkg::CH_LF);
				end
				default: add_sentence();
			endcase
			send_line();
		end
		byte_valid <= 1'b0;

		// Drain the outstanding lines, then let the pipeline settle
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes; checked %0d line results, %0d of them good fixes.",
			bytes_sent, board.lines_checked, board.good_fixes);
		if (board.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// End the run if neither side moves an item for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
				idle = 0;
			else
				idle++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule
